// ===== sv/input_alarm_output_mapper_macros.svh =====
// Assertion macros shared by the input alarm output mapper modules.
`ifndef INPUT_ALARM_OUTPUT_MAPPER_MACROS_SVH
`define INPUT_ALARM_OUTPUT_MAPPER_MACROS_SVH

// Same-cycle implication, checked on every rising clock edge out of reset.
`define IAOM_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("iaom assertion failed");

// Next-cycle implication, checked on every rising clock edge out of reset.
`define IAOM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("iaom assertion failed");

`endif

// ===== sv/iaom_pkg.sv =====
// Shared constants of the input alarm output mapper.
package iaom_pkg;

	// Configuration port geometry.
	localparam int APB_DW = 32;
	localparam int ADDR_W = 5;
	localparam int REG_IDX_W = 3;

	// Register indexes on the configuration port (byte address is 4 * index).
	localparam logic [REG_IDX_W-1:0] REG_NORMAL_LEVELS = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_INPUT_INVERT = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_OUTPUT_INVERT = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_OVERRIDE_MASK = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_INPUT_MAP = 3'd4;

	// Each input owns one nibble of the map register.
	localparam int NIBBLE_W = 4;

	// Depth of the queue between the classifier and the output stage.
	localparam int QUEUE_DEPTH = 2;

endpackage

// ===== sv/input_alarm_output_mapper.sv =====
// Top level of the input alarm output mapper.
// Each input beat on s_tdata is one sample of the raw input pin levels and gives exactly one
// result beat on m_tdata: the inputs whose alarm status changed, the inputs now abnormal, the
// logical output state and the pin drive levels. The block takes one sample per clock cycle while
// the queue has room; each sample is registered in the queue and its result in the output stage.
// The front end classifies a sample in the cycle it is accepted, a two-entry queue holds
// classified samples, and the output stage applies them to the output state and holds the
// result beat, so a stalled m_tready does not stop sampling until the queue is full. Configuration is
// to be written through the APB-style port only while no sample is in flight; the block has no check for it.
module input_alarm_output_mapper #(
	parameter int NUM_INPUTS = 7,
	parameter int NUM_OUTPUTS = 5
) (
	input  logic                        clk,
	input  logic                        arst_n,
	// Input samples.
	input  logic                        s_tvalid,
	output logic                        s_tready,
	input  logic [((NUM_INPUTS+7)/8)*8-1:0] s_tdata, // pin_levels
	// Results.
	output logic                        m_tvalid,
	input  logic                        m_tready,
	output logic [((2*NUM_INPUTS+2*NUM_OUTPUTS+7)/8)*8-1:0] m_tdata, // changed_mask, abnormal_mask, output_state, pin_drive
	// Configuration.
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [iaom_pkg::ADDR_W-1:0] paddr,
	input  logic [iaom_pkg::APB_DW-1:0] pwdata,
	output logic [iaom_pkg::APB_DW-1:0] prdata,
	output logic                        pready
);

	localparam int MAP_W = iaom_pkg::NIBBLE_W * NUM_INPUTS;
	localparam int ENTRY_W = 2 * NUM_INPUTS + 2 * NUM_OUTPUTS;
	localparam int OUT_TW = ((2 * NUM_INPUTS + 2 * NUM_OUTPUTS + 7) / 8) * 8;

	logic [NUM_INPUTS-1:0]  normal_levels;
	logic [NUM_INPUTS-1:0]  input_invert;
	logic [NUM_OUTPUTS-1:0] output_invert;
	logic [NUM_OUTPUTS-1:0] override_mask;
	logic [MAP_W-1:0]       input_map;

	logic                   accept;
	logic [NUM_INPUTS-1:0]  f_changed;
	logic [NUM_INPUTS-1:0]  f_abnormal;
	logic [NUM_OUTPUTS-1:0] f_we;
	logic [NUM_OUTPUTS-1:0] f_val;

	logic [ENTRY_W-1:0]     push_data;
	logic [ENTRY_W-1:0]     pop_data;
	logic                   pop_valid;
	logic                   pop;

	logic [NUM_INPUTS-1:0]  r_changed;
	logic [NUM_INPUTS-1:0]  r_abnormal;
	logic [NUM_OUTPUTS-1:0] r_state;
	logic [NUM_OUTPUTS-1:0] r_drive;

	iaom_regs #(
		.NUM_INPUTS(NUM_INPUTS),
		.NUM_OUTPUTS(NUM_OUTPUTS)
	) u_regs (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.normal_levels(normal_levels),
		.input_invert(input_invert),
		.output_invert(output_invert),
		.override_mask(override_mask),
		.input_map(input_map)
	);

	assign accept = s_tvalid && s_tready;

	iaom_front #(
		.NUM_INPUTS(NUM_INPUTS),
		.NUM_OUTPUTS(NUM_OUTPUTS)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.accept(accept),
		.pin_levels(s_tdata[NUM_INPUTS-1:0]),
		.normal_levels(normal_levels),
		.input_invert(input_invert),
		.override_mask(override_mask),
		.input_map(input_map),
		.changed_mask(f_changed),
		.abnormal_mask(f_abnormal),
		.out_we(f_we),
		.out_val(f_val)
	);

	// Queue entry, lowest bits first: changed, abnormal, write enables, write values.
	assign push_data = {f_val, f_we, f_abnormal, f_changed};

	iaom_queue #(
		.WIDTH(ENTRY_W)
	) u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(s_tvalid),
		.push_data(push_data),
		.push_ready(s_tready),
		.pop(pop),
		.pop_data(pop_data),
		.pop_valid(pop_valid)
	);

	iaom_back #(
		.NUM_INPUTS(NUM_INPUTS),
		.NUM_OUTPUTS(NUM_OUTPUTS)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.q_valid(pop_valid),
		.q_pop(pop),
		.changed_mask(pop_data[NUM_INPUTS-1:0]),
		.abnormal_mask(pop_data[2*NUM_INPUTS-1:NUM_INPUTS]),
		.out_we(pop_data[2*NUM_INPUTS+NUM_OUTPUTS-1:2*NUM_INPUTS]),
		.out_val(pop_data[ENTRY_W-1:2*NUM_INPUTS+NUM_OUTPUTS]),
		.output_invert(output_invert),
		.res_valid(m_tvalid),
		.res_ready(m_tready),
		.res_changed(r_changed),
		.res_abnormal(r_abnormal),
		.res_state(r_state),
		.res_drive(r_drive)
	);

	// Result beat, zero-filled to whole bytes.
	assign m_tdata = OUT_TW'({r_drive, r_state, r_abnormal, r_changed});

endmodule

// ===== sv/iaom_regs.sv =====
// Configuration register file with its APB-style access port.
module iaom_regs #(
	parameter int NUM_INPUTS = 7,
	parameter int NUM_OUTPUTS = 5
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic [iaom_pkg::ADDR_W-1:0]        paddr,
	input  logic [iaom_pkg::APB_DW-1:0]        pwdata,
	output logic [iaom_pkg::APB_DW-1:0]        prdata,
	output logic                               pready,
	output logic [NUM_INPUTS-1:0]              normal_levels,
	output logic [NUM_INPUTS-1:0]              input_invert,
	output logic [NUM_OUTPUTS-1:0]             output_invert,
	output logic [NUM_OUTPUTS-1:0]             override_mask,
	output logic [iaom_pkg::NIBBLE_W*NUM_INPUTS-1:0] input_map
);

	localparam int MAP_W = iaom_pkg::NIBBLE_W * NUM_INPUTS;

	logic [NUM_INPUTS-1:0]  normal_q;
	logic [NUM_INPUTS-1:0]  in_inv_q;
	logic [NUM_OUTPUTS-1:0] out_inv_q;
	logic [NUM_OUTPUTS-1:0] ovr_q;
	logic [MAP_W-1:0]       map_q;
	logic [iaom_pkg::REG_IDX_W-1:0] reg_idx;
	logic                   wr_en;

	assign pready = 1'b1;
	assign reg_idx = paddr[iaom_pkg::ADDR_W-1:2];
	assign wr_en = psel & penable & pwrite & pready;

	// Register writes; addresses beyond the register list are ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			normal_q <= '1;
			in_inv_q <= '0;
			out_inv_q <= '0;
			ovr_q <= '0;
			map_q <= '1;
		end else if (wr_en) begin
			case (reg_idx)
				iaom_pkg::REG_NORMAL_LEVELS: normal_q <= pwdata[NUM_INPUTS-1:0];
				iaom_pkg::REG_INPUT_INVERT: in_inv_q <= pwdata[NUM_INPUTS-1:0];
				iaom_pkg::REG_OUTPUT_INVERT: out_inv_q <= pwdata[NUM_OUTPUTS-1:0];
				iaom_pkg::REG_OVERRIDE_MASK: ovr_q <= pwdata[NUM_OUTPUTS-1:0];
				iaom_pkg::REG_INPUT_MAP: map_q <= pwdata[MAP_W-1:0];
				default: ;
			endcase
		end
	end

	// Read-back multiplexer; unused addresses read as zero.
	always_comb begin
		case (reg_idx)
			iaom_pkg::REG_NORMAL_LEVELS: prdata = iaom_pkg::APB_DW'(normal_q);
			iaom_pkg::REG_INPUT_INVERT: prdata = iaom_pkg::APB_DW'(in_inv_q);
			iaom_pkg::REG_OUTPUT_INVERT: prdata = iaom_pkg::APB_DW'(out_inv_q);
			iaom_pkg::REG_OVERRIDE_MASK: prdata = iaom_pkg::APB_DW'(ovr_q);
			iaom_pkg::REG_INPUT_MAP: prdata = iaom_pkg::APB_DW'(map_q);
			default: prdata = '0;
		endcase
	end

	assign normal_levels = normal_q;
	assign input_invert = in_inv_q;
	assign output_invert = out_inv_q;
	assign override_mask = ovr_q;
	assign input_map = map_q;

endmodule

// ===== sv/iaom_front.sv =====
// Front end: takes pin samples, finds abnormal and changed inputs, and works out output updates.
module iaom_front #(
	parameter int NUM_INPUTS = 7,
	parameter int NUM_OUTPUTS = 5
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               accept,
	input  logic [NUM_INPUTS-1:0]              pin_levels,
	input  logic [NUM_INPUTS-1:0]              normal_levels,
	input  logic [NUM_INPUTS-1:0]              input_invert,
	input  logic [NUM_OUTPUTS-1:0]             override_mask,
	input  logic [iaom_pkg::NIBBLE_W*NUM_INPUTS-1:0] input_map,
	output logic [NUM_INPUTS-1:0]              changed_mask,
	output logic [NUM_INPUTS-1:0]              abnormal_mask,
	output logic [NUM_OUTPUTS-1:0]             out_we,
	output logic [NUM_OUTPUTS-1:0]             out_val
);

	logic [NUM_INPUTS-1:0] prev_abnormal_q;
	logic [NUM_INPUTS-1:0] abnormal;
	logic [NUM_INPUTS-1:0] changed;
	logic [NUM_INPUTS-1:0] upd_en;
	logic [NUM_OUTPUTS-1:0] target_oh [NUM_INPUTS];

	// Abnormal inputs after inversion, and changes against the previous sample.
	assign abnormal = (pin_levels ^ input_invert) ^ normal_levels;
	assign changed = abnormal ^ prev_abnormal_q;

	// Decode each input's map nibble into a one-hot output select.
	// A nibble that names no output gives an all-zero select, so the input is unmapped.
	always_comb begin
		for (int i = 0; i < NUM_INPUTS; i++) begin
			for (int k = 0; k < NUM_OUTPUTS; k++) begin
				target_oh[i][k] = (input_map[iaom_pkg::NIBBLE_W*i +: iaom_pkg::NIBBLE_W]
					== iaom_pkg::NIBBLE_W'(k));
			end
		end
	end

	// An input updates its output when it changed, is mapped, is not a return
	// to normal on an overridden output, and no other input on that output is abnormal.
	always_comb begin
		logic blocked;
		for (int i = 0; i < NUM_INPUTS; i++) begin
			blocked = 1'b0;
			for (int j = 0; j < NUM_INPUTS; j++) begin
				if (j != i && abnormal[j] && ((target_oh[i] & target_oh[j]) != '0)) begin
					blocked = 1'b1;
				end
			end
			upd_en[i] = changed[i] && (target_oh[i] != '0)
				&& (abnormal[i] || ((target_oh[i] & override_mask) == '0))
				&& !blocked;
		end
	end

	// Per output, the highest updating input wins, as the inputs are applied lowest first.
	always_comb begin
		out_we = '0;
		out_val = '0;
		for (int k = 0; k < NUM_OUTPUTS; k++) begin
			for (int i = 0; i < NUM_INPUTS; i++) begin
				if (upd_en[i] && target_oh[i][k]) begin
					out_we[k] = 1'b1;
					out_val[k] = abnormal[i];
				end
			end
		end
	end

	// The previous mask moves on with every accepted sample.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_abnormal_q <= '0;
		end else if (accept) begin
			prev_abnormal_q <= abnormal;
		end
	end

	assign changed_mask = changed;
	assign abnormal_mask = abnormal;

endmodule

// ===== sv/iaom_queue.sv =====
// Short queue that decouples the classifier from the output stage.
`include "input_alarm_output_mapper_macros.svh"
module iaom_queue #(
	parameter int WIDTH = 24
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	output logic             push_ready,
	input  logic             pop,
	output logic [WIDTH-1:0] pop_data,
	output logic             pop_valid
);

	localparam int DEPTH = iaom_pkg::QUEUE_DEPTH;
	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign push_ready = (count_q != CNT_W'(DEPTH));
	assign pop_valid = (count_q != '0);
	assign do_push = push && push_ready;
	assign do_pop = pop && pop_valid;
	assign pop_data = mem_q[rd_ptr_q];

	// Entry storage.
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	`IAOM_ASSERT_NOW(a_count_bound, clk, arst_n, 1'b1, count_q <= CNT_W'(DEPTH))
	`IAOM_ASSERT_NEXT(a_push_fills, clk, arst_n, do_push && !do_pop, count_q == $past(count_q) + 1'b1)
	`IAOM_ASSERT_NEXT(a_pop_drains, clk, arst_n, do_pop && !do_push, count_q == $past(count_q) - 1'b1)

endmodule

// ===== sv/iaom_back.sv =====
// Back end: applies output updates to the output state and holds the result beat.
`include "input_alarm_output_mapper_macros.svh"
module iaom_back #(
	parameter int NUM_INPUTS = 7,
	parameter int NUM_OUTPUTS = 5
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   q_valid,
	output logic                   q_pop,
	input  logic [NUM_INPUTS-1:0]  changed_mask,
	input  logic [NUM_INPUTS-1:0]  abnormal_mask,
	input  logic [NUM_OUTPUTS-1:0] out_we,
	input  logic [NUM_OUTPUTS-1:0] out_val,
	input  logic [NUM_OUTPUTS-1:0] output_invert,
	output logic                   res_valid,
	input  logic                   res_ready,
	output logic [NUM_INPUTS-1:0]  res_changed,
	output logic [NUM_INPUTS-1:0]  res_abnormal,
	output logic [NUM_OUTPUTS-1:0] res_state,
	output logic [NUM_OUTPUTS-1:0] res_drive
);

	logic                   out_valid_q;
	logic [NUM_OUTPUTS-1:0] bits_q;
	logic [NUM_OUTPUTS-1:0] bits_nxt;
	logic [NUM_INPUTS-1:0]  changed_q;
	logic [NUM_INPUTS-1:0]  abnormal_q;
	logic [NUM_OUTPUTS-1:0] state_q;
	logic [NUM_OUTPUTS-1:0] drive_q;

	// Take the next entry whenever the result register is empty or being drained.
	assign q_pop = q_valid && (!out_valid_q || res_ready);
	assign bits_nxt = (bits_q & ~out_we) | (out_val & out_we);

	// Output state and result valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bits_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (q_pop) begin
				bits_q <= bits_nxt;
				out_valid_q <= 1'b1;
			end else if (res_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Result payload.
	always_ff @(posedge clk) begin
		if (q_pop) begin
			changed_q <= changed_mask;
			abnormal_q <= abnormal_mask;
			state_q <= bits_nxt;
			drive_q <= bits_nxt ^ output_invert;
		end
	end

	assign res_valid = out_valid_q;
	assign res_changed = changed_q;
	assign res_abnormal = abnormal_q;
	assign res_state = state_q;
	assign res_drive = drive_q;

	`IAOM_ASSERT_NOW(a_state_matches, clk, arst_n, out_valid_q, state_q == bits_q)
	`IAOM_ASSERT_NEXT(a_bits_hold, clk, arst_n, !q_pop, $stable(bits_q))
	`IAOM_ASSERT_NEXT(a_pop_gives_beat, clk, arst_n, q_pop, out_valid_q)

endmodule

// ===== dv/tb_input_alarm_output_mapper.sv =====
// Self-checking testbench for the input alarm output mapper: directed table, then random phases.
`default_nettype none

module tb_input_alarm_output_mapper;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NUM_IN = 7;
	localparam int NUM_OUT = 5;
	localparam int S_W = ((NUM_IN + 7) / 8) * 8;
	localparam int M_W = ((2 * NUM_IN + 2 * NUM_OUT + 7) / 8) * 8;
	localparam int RES_W = 2 * NUM_IN + 2 * NUM_OUT;
	localparam int HOLD_CYCLES = 400;
	localparam int WATCHDOG_LIMIT = 5000;
	localparam int NUM_PHASES = 12;
	localparam int SAMPLES_PER_PHASE = 104;
	localparam int NUM_DIRECTED = 24;

	// Register slots past the end of the register list; writes there are dropped.
	localparam logic [iaom_pkg::REG_IDX_W-1:0] REG_PAST_END = 3'd5;
	localparam logic [iaom_pkg::REG_IDX_W-1:0] REG_TOP_SLOT = 3'd7;

	// One result beat, laid out as on m_tdata (changed mask in the lowest bits).
	typedef struct packed {
		logic [NUM_OUT-1:0] pin_drive;
		logic [NUM_OUT-1:0] output_state;
		logic [NUM_IN-1:0]  abnormal_mask;
		logic [NUM_IN-1:0]  changed_mask;
	} alarm_result_t;

	typedef enum bit {ROW_WRITE, ROW_SAMPLE} row_kind_t;

	// One row of the directed table: a register write or a pin sample.
	typedef struct packed {
		row_kind_t          kind;
		logic [2:0]         idx;
		logic [31:0]        value;
		bit                 typed;
		alarm_result_t      result;
	} directed_row_t;

	logic              clk;
	logic              arst_n;
	logic              s_tvalid;
	logic              s_tready;
	logic [S_W-1:0]    s_tdata;   // pin_levels
	logic              m_tvalid;
	logic              m_tready;
	logic [M_W-1:0]    m_tdata;   // changed_mask, abnormal_mask, output_state, pin_drive
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [iaom_pkg::ADDR_W-1:0] paddr;
	logic [iaom_pkg::APB_DW-1:0] pwdata;
	logic [iaom_pkg::APB_DW-1:0] prdata;
	logic              pready;

	input_alarm_output_mapper #(
		.NUM_INPUTS(NUM_IN),
		.NUM_OUTPUTS(NUM_OUT)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	// Mirror of the block's configuration and alarm state.
	logic [NUM_IN-1:0]    cfg_normal = '1;
	logic [NUM_IN-1:0]    cfg_input_invert = '0;
	logic [NUM_OUT-1:0]   cfg_output_invert = '0;
	logic [NUM_OUT-1:0]   cfg_override = '0;
	logic [4*NUM_IN-1:0]  cfg_map = '1;
	logic [NUM_IN-1:0]    prev_abnormal = '0;
	logic [NUM_OUT-1:0]   alarm_outputs = '0;

	alarm_result_t pending_results[$];
	int            errors = 0;
	int            n_samples = 0;
	int            n_results = 0;
	int            n_writes = 0;
	bit            send_fast = 0;
	bit            drain_fast = 0;
	bit            hold_req = 0;
	int            holds_done = 0;
	directed_row_t directed_rows [0:NUM_DIRECTED-1];

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Applies one pin sample to the mirrored state and returns the result it must produce.
	function automatic alarm_result_t apply_sample(logic [NUM_IN-1:0] pins);
		logic [NUM_IN-1:0] abnormal;
		logic [NUM_IN-1:0] changed;
		logic [3:0]        target;
		bit                blocked;
		alarm_result_t     r;
		abnormal = (pins ^ cfg_input_invert) ^ cfg_normal;
		changed = abnormal ^ prev_abnormal;
		for (int i = 0; i < NUM_IN; i++) begin
			if (!changed[i])
				continue;
			target = cfg_map[4*i +: 4];
			if (target >= NUM_OUT)
				continue;
			// A return to normal leaves an overridden output on.
			if (!abnormal[i] && cfg_override[target])
				continue;
			// Another abnormal input sharing the output keeps it as it is.
			blocked = 0;
			for (int j = 0; j < NUM_IN; j++) begin
				if (j != i && cfg_map[4*j +: 4] == target && abnormal[j])
					blocked = 1;
			end
			if (!blocked)
				alarm_outputs[target] = abnormal[i];
		end
		prev_abnormal = abnormal;
		r.changed_mask = changed;
		r.abnormal_mask = abnormal;
		r.output_state = alarm_outputs;
		r.pin_drive = alarm_outputs ^ cfg_output_invert;
		return r;
	endfunction

	task automatic report(string what, int got, int want);
		$display("mismatch on result %0d: %s is 0x%0h, expected 0x%0h",
			n_results, what, got, want);
		errors++;
	endtask

	// Writes one register over the configuration port and updates the mirror.
	task automatic reg_write(logic [iaom_pkg::REG_IDX_W-1:0] idx, logic [31:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		n_writes++;
		case (idx)
			iaom_pkg::REG_NORMAL_LEVELS: cfg_normal = value[NUM_IN-1:0];
			iaom_pkg::REG_INPUT_INVERT:  cfg_input_invert = value[NUM_IN-1:0];
			iaom_pkg::REG_OUTPUT_INVERT: cfg_output_invert = value[NUM_OUT-1:0];
			iaom_pkg::REG_OVERRIDE_MASK: cfg_override = value[NUM_OUT-1:0];
			iaom_pkg::REG_INPUT_MAP:     cfg_map = value[4*NUM_IN-1:0];
			default: ;
		endcase
	endtask

	// Offers one sample after a random gap and queues its expected result once it is taken.
	task automatic send_sample(logic [NUM_IN-1:0] pins, bit typed, alarm_result_t typed_result);
		int            gap;
		alarm_result_t predicted;
		gap = send_fast ? 0 : $urandom_range(0, 15);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {{(S_W-NUM_IN){1'b0}}, pins};
		do @(posedge clk); while (!s_tready);
		predicted = apply_sample(pins);
		pending_results.push_back(typed ? typed_result : predicted);
		n_samples++;
	endtask

	// Stops offering samples and waits until every expected result has been seen.
	task automatic settle();
		s_tvalid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Result side: random stalls, one long hold on request, and the scoreboard check.
	initial begin
		alarm_result_t got;
		alarm_result_t want;
		int            stall;
		m_tready <= 1'b0;
		@(posedge clk);
		while (!arst_n)
			@(posedge clk);
		forever begin
			stall = drain_fast ? 0 : $urandom_range(0, 15);
			if (hold_req) begin
				stall = HOLD_CYCLES;
				hold_req = 0;
				holds_done++;
			end
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
			got = alarm_result_t'(m_tdata[RES_W-1:0]);
			n_results++;
			if (pending_results.size() == 0) begin
				report("unexpected result beat", int'(got), 0);
			end else begin
				want = pending_results.pop_front();
				if (got.changed_mask !== want.changed_mask)
					report("changed_mask", int'(got.changed_mask),
						int'(want.changed_mask));
				if (got.abnormal_mask !== want.abnormal_mask)
					report("abnormal_mask", int'(got.abnormal_mask),
						int'(want.abnormal_mask));
				if (got.output_state !== want.output_state)
					report("output_state", int'(got.output_state),
						int'(want.output_state));
				if (got.pin_drive !== want.pin_drive)
					report("pin_drive", int'(got.pin_drive), int'(want.pin_drive));
			end
		end
	end

	// Watchdog on cycles in which no beat and no register write is taken.
	initial begin
		int idle_cycles;
		idle_cycles = 0;
		forever begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) ||
				(psel && penable && pwrite && pready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("watchdog: no progress for %0d cycles, %0d results outstanding",
					idle_cycles, pending_results.size());
				$display("SCOREBOARD MISMATCH");
				$finish;
			end
		end
	end

	// Stimulus: reset, directed table, then random configuration phases.
	initial begin
		logic [NUM_IN-1:0] pins;
		logic [31:0]       map_value;
		// Rows: result field is {pin_drive, output_state, abnormal_mask, changed_mask}.
		directed_rows = '{
			// Reset settings: all inputs normal when high, every input unmapped.
			'{ROW_SAMPLE, 3'd0, 32'h7F, 1'b1, {5'h00, 5'h00, 7'h00, 7'h00}},
			'{ROW_SAMPLE, 3'd0, 32'h00, 1'b1, {5'h00, 5'h00, 7'h7F, 7'h7F}},
			'{ROW_SAMPLE, 3'd0, 32'h7F, 1'b1, {5'h00, 5'h00, 7'h00, 7'h7F}},
			// Inputs 0..4 to outputs 0..4, inputs 5 and 6 share output 0; junk in high bits.
			'{ROW_WRITE, iaom_pkg::REG_INPUT_MAP, 32'hF004_3210, 1'b0, '0},
			'{ROW_WRITE, iaom_pkg::REG_OUTPUT_INVERT, 32'hFFFF_FFE5, 1'b0, '0},
			'{ROW_WRITE, iaom_pkg::REG_OVERRIDE_MASK, 32'h0000_0002, 1'b0, '0},
			'{ROW_WRITE, iaom_pkg::REG_INPUT_INVERT, 32'hFFFF_FF80, 1'b0, '0},
			'{ROW_WRITE, iaom_pkg::REG_NORMAL_LEVELS, 32'h0000_007F, 1'b0, '0},
			'{ROW_SAMPLE, 3'd0, 32'h7E, 1'b1, {5'h04, 5'h01, 7'h01, 7'h01}},
			'{ROW_SAMPLE, 3'd0, 32'h7C, 1'b1, {5'h06, 5'h03, 7'h03, 7'h02}},
			// Input 1 returns to normal while its output is overridden.
			'{ROW_SAMPLE, 3'd0, 32'h7E, 1'b1, {5'h06, 5'h03, 7'h01, 7'h02}},
			// Inputs 5 and 6 go abnormal but output 0 is held by input 0.
			'{ROW_SAMPLE, 3'd0, 32'h1E, 1'b1, {5'h06, 5'h03, 7'h61, 7'h60}},
			'{ROW_SAMPLE, 3'd0, 32'h7F, 1'b1, {5'h07, 5'h02, 7'h00, 7'h61}},
			'{ROW_SAMPLE, 3'd0, 32'h00, 1'b1, {5'h1B, 5'h1E, 7'h7F, 7'h7F}},
			// Writes past the register list must leave every setting alone.
			'{ROW_WRITE, REG_PAST_END, 32'h0000_007F, 1'b0, '0},
			'{ROW_WRITE, REG_TOP_SLOT, 32'h0000_007F, 1'b0, '0},
			'{ROW_SAMPLE, 3'd0, 32'h00, 1'b1, {5'h1B, 5'h1E, 7'h7F, 7'h00}},
			'{ROW_WRITE, iaom_pkg::REG_INPUT_INVERT, 32'h0000_007F, 1'b0, '0},
			'{ROW_WRITE, iaom_pkg::REG_NORMAL_LEVELS, 32'h0000_0000, 1'b0, '0},
			'{ROW_WRITE, iaom_pkg::REG_OVERRIDE_MASK, 32'h0000_001F, 1'b0, '0},
			'{ROW_WRITE, iaom_pkg::REG_OUTPUT_INVERT, 32'h0000_001F, 1'b0, '0},
			'{ROW_SAMPLE, 3'd0, 32'h7F, 1'b1, {5'h01, 5'h1E, 7'h00, 7'h7F}},
			'{ROW_SAMPLE, 3'd0, 32'h55, 1'b0, '0},
			'{ROW_SAMPLE, 3'd0, 32'h2A, 1'b0, '0}
		};

		arst_n <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed table; writes wait for the block to go idle.
		foreach (directed_rows[r]) begin
			if (directed_rows[r].kind == ROW_WRITE) begin
				settle();
				reg_write(directed_rows[r].idx, directed_rows[r].value);
			end else begin
				send_sample(directed_rows[r].value[NUM_IN-1:0], directed_rows[r].typed,
					directed_rows[r].result);
			end
		end

		// Random phases: fresh settings, then mostly single-pin alarm events.
		pins = '1;
		for (int phase = 0; phase < NUM_PHASES; phase++) begin
			settle();
			send_fast = (phase % 4 == 1);
			drain_fast = (phase % 3 == 2);
			if (phase == 0) begin
				reg_write(iaom_pkg::REG_NORMAL_LEVELS, '0);
				reg_write(iaom_pkg::REG_INPUT_INVERT, '0);
				reg_write(iaom_pkg::REG_OUTPUT_INVERT, '0);
				reg_write(iaom_pkg::REG_OVERRIDE_MASK, '0);
				reg_write(iaom_pkg::REG_INPUT_MAP, '0);
			end else if (phase == 1) begin
				reg_write(iaom_pkg::REG_NORMAL_LEVELS, '1);
				reg_write(iaom_pkg::REG_INPUT_INVERT, '1);
				reg_write(iaom_pkg::REG_OUTPUT_INVERT, '1);
				reg_write(iaom_pkg::REG_OVERRIDE_MASK, '1);
				reg_write(iaom_pkg::REG_INPUT_MAP, '1);
			end else begin
				map_value = $urandom;
				for (int k = 0; k < NUM_IN; k++)
					map_value[4*k +: 4] = ($urandom_range(0, 9) < 8) ?
						4'($urandom_range(0, NUM_OUT - 1)) :
						4'($urandom_range(NUM_OUT, 15));
				reg_write(iaom_pkg::REG_INPUT_MAP, map_value);
				reg_write(iaom_pkg::REG_NORMAL_LEVELS, $urandom);
				reg_write(iaom_pkg::REG_INPUT_INVERT, $urandom);
				reg_write(iaom_pkg::REG_OUTPUT_INVERT, $urandom);
				reg_write(iaom_pkg::REG_OVERRIDE_MASK, $urandom);
			end
			// One phase stalls the result side for a long stretch while samples keep coming.
			if (phase == 3) begin
				send_fast = 1;
				hold_req = 1;
			end
			for (int n = 0; n < SAMPLES_PER_PHASE; n++) begin
				case ($urandom_range(0, 9))
					0, 1:    pins = NUM_IN'($urandom);
					2:       pins = pins;
					default: pins = pins ^ (7'd1 << $urandom_range(0, NUM_IN - 1));
				endcase
				send_sample(pins, 1'b0, '0);
			end
		end

		settle();
		repeat (10) @(posedge clk);
		$display("Run covered %0d pin samples, %0d result beats, %0d register writes,",
			n_samples, n_results, n_writes);
		$display("%0d configuration phases and %0d long result-side holds.",
			NUM_PHASES, holds_done);
		if (errors == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule

`default_nettype wire
